// ===== hw/rtl/fp8dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP8 dequantiser package
// Shared payload types, stage record, register indexes and action codes.
// ----------------------------------------------------------------------------
package fp8dq_pkg;

    localparam int COUNT_W = 16;
    localparam int CFG_W   = 17;
    localparam int SLOT_W  = 12;

    localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic ACT_SCALE  = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 17'd128;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] scale_slot;
        logic [7:0]        data_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] bf16_word;
        logic        last_element;
    } result_t;

    // Control record that travels down the pipeline with each item.
    typedef struct packed {
        logic       valid;
        logic       action;
        logic       last;
        logic [7:0] data;
    } stage_t;

endpackage

// ===== hw/rtl/fp8_block_scaled_dequant_bf16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP8 block-scaled dequantiser to BF16
// Converts E4M3 weights with per-tile E8M0 scales into BF16 words.
// ----------------------------------------------------------------------------
// Usage. Items enter on the item channel (valid/ready). An item with action
// 0 writes its data byte as the scale of tile scale_slot; it yields no
// result. An item with action 1 is one weight byte of the matrix in
// row-major order and yields one transfer on the result channel, with
// last_element set on the final element of the matrix.
// The configuration port sets the row and column counts; write it only
// while the block is idle.
// Throughput is one item per cycle: index forming, the modulo reduction,
// the scale memory access and the conversion each take one pipeline stage,
// and the scale memory is touched once per item, so writes and reads never
// collide and a scale written by one item is seen by the very next one.
// When the receiver stalls the whole pipeline holds and item_ready drops;
// items already inside wait in their stages.
// Reset empties the pipeline, clears the position counters and sets both
// counts to 128. The scale memory is not cleared; scales must be written
// before the weights of their tile are sent.
// ----------------------------------------------------------------------------
module fp8_block_scaled_dequant_bf16 #(
    parameter int MAX_SCALE_ENTRIES = 4096,
    parameter int TILE_SIZE         = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  fp8dq_pkg::item_t            item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output fp8dq_pkg::result_t          result,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [fp8dq_pkg::CFG_W-1:0] cfg_data
);
    import fp8dq_pkg::*;

    localparam int TW  = $clog2(TILE_SIZE);
    localparam int RTW = $clog2(65535 / TILE_SIZE + 1);
    localparam int AW  = (MAX_SCALE_ENTRIES > 1) ? $clog2(MAX_SCALE_ENTRIES) : 1;

    logic [CFG_W-1:0]   row_count_reg;
    logic [CFG_W-1:0]   column_count_reg;
    logic [CFG_W-1:0]   rows_eff;
    logic [CFG_W-1:0]   cols_eff;

    logic [COUNT_W-1:0] row_pos_reg;
    logic [COUNT_W-1:0] col_pos_reg;
    logic [TW-1:0]      row_in_tile_reg;
    logic [TW-1:0]      col_in_tile_reg;
    logic [RTW-1:0]     row_tile_reg;
    logic [RTW-1:0]     col_tile_reg;

    logic               adv;
    logic               accept;
    logic               col_end;
    logic               last_now;

    stage_t             s1_reg;
    logic [RTW-1:0]     rt1_reg;
    logic [RTW-1:0]     ct1_reg;
    logic [SLOT_W-1:0]  slot1_reg;
    stage_t             s3;
    logic [AW-1:0]      ram_addr;
    stage_t             s4_reg;
    logic [7:0]         scale_q;
    logic [15:0]        bf16;

    logic               result_valid_reg;
    result_t            result_reg;

    // The pipeline moves as one whenever the output register can take a result.
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && adv;

    assign rows_eff = (row_count_reg[COUNT_W-1:0] == '0)
                    ? CFG_W'(1 << COUNT_W) : {1'b0, row_count_reg[COUNT_W-1:0]};
    assign cols_eff = (column_count_reg[COUNT_W-1:0] == '0)
                    ? CFG_W'(1 << COUNT_W) : {1'b0, column_count_reg[COUNT_W-1:0]};

    // A position at or past its count acts as the end of the row or matrix.
    assign col_end  = (CFG_W'(col_pos_reg) + CFG_W'(1)) >= cols_eff;
    assign last_now = col_end && ((CFG_W'(row_pos_reg) + CFG_W'(1)) >= rows_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_RESET;
            column_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    // Position counters, with the tile number and offset kept alongside so
    // that no division is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            row_in_tile_reg <= '0;
            col_in_tile_reg <= '0;
            row_tile_reg    <= '0;
            col_tile_reg    <= '0;
        end
        else if (accept && (item.action == ACT_WEIGHT))
        begin
            priority if (last_now)
            begin
                row_pos_reg     <= '0;
                col_pos_reg     <= '0;
                row_in_tile_reg <= '0;
                col_in_tile_reg <= '0;
                row_tile_reg    <= '0;
                col_tile_reg    <= '0;
            end
            else if (col_end)
            begin
                col_pos_reg     <= '0;
                col_in_tile_reg <= '0;
                col_tile_reg    <= '0;
                row_pos_reg     <= row_pos_reg + COUNT_W'(1);
                if (row_in_tile_reg == TW'(TILE_SIZE - 1))
                begin
                    row_in_tile_reg <= '0;
                    row_tile_reg    <= row_tile_reg + RTW'(1);
                end
                else
                begin
                    row_in_tile_reg <= row_in_tile_reg + TW'(1);
                end
            end
            else
            begin
                col_pos_reg <= col_pos_reg + COUNT_W'(1);
                if (col_in_tile_reg == TW'(TILE_SIZE - 1))
                begin
                    col_in_tile_reg <= '0;
                    col_tile_reg    <= col_tile_reg + RTW'(1);
                end
                else
                begin
                    col_in_tile_reg <= col_in_tile_reg + TW'(1);
                end
            end
        end
    end

    // Capture stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg.valid  <= item_valid;
            s1_reg.action <= item.action;
            s1_reg.last   <= last_now;
            s1_reg.data   <= item.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt1_reg   <= row_tile_reg;
            ct1_reg   <= col_tile_reg;
            slot1_reg <= item.scale_slot;
        end
    end

    fp8dq_index #(
        .TILE_SIZE         (TILE_SIZE),
        .MAX_SCALE_ENTRIES (MAX_SCALE_ENTRIES)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .s_in     (s1_reg),
        .row_tile (rt1_reg),
        .col_tile (ct1_reg),
        .slot     (slot1_reg),
        .cols_eff (cols_eff),
        .s_out    (s3),
        .addr     (ram_addr)
    );

    fp8dq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SCALE_ENTRIES)
    ) u_scale_ram (
        .clk   (clk),
        .en    (adv),
        .we    (s3.valid && (s3.action == ACT_SCALE)),
        .addr  (ram_addr),
        .wdata (s3.data),
        .rdata (scale_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
        end
        else if (adv)
        begin
            s4_reg <= s3;
        end
    end

    fp8dq_convert u_convert (
        .weight (s4_reg.data),
        .scale  (scale_q),
        .bf16   (bf16)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= s4_reg.valid && (s4_reg.action == ACT_WEIGHT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.bf16_word    <= bf16;
            result_reg.last_element <= s4_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A held result must stall the input side.
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !item_ready
    ) else $error("item accepted while a result was stalled");

    // Tile offsets stay inside a tile.
    a_tile_offset_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (row_in_tile_reg <= TW'(TILE_SIZE - 1)) && (col_in_tile_reg <= TW'(TILE_SIZE - 1))
    ) else $error("tile offset out of range");

    // The final element of a matrix returns both positions to the origin.
    a_last_restarts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (item.action == ACT_WEIGHT) && last_now)
            |=> ((row_pos_reg == '0) && (col_pos_reg == '0) && (row_tile_reg == '0))
    ) else $error("positions not cleared after last element");

endmodule

// ===== hw/rtl/fp8dq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Reads every enabled cycle, writes too when we is set; read data registered.
// ----------------------------------------------------------------------------
module fp8dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hw/rtl/fp8dq_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP8 dequantiser scale index unit
// Forms tile index or scale slot, then reduces it modulo store depth, over two stages.
// ----------------------------------------------------------------------------
module fp8dq_index #(
    parameter int TILE_SIZE         = 128,
    parameter int MAX_SCALE_ENTRIES = 4096,
    parameter int RTW = $clog2(65535 / TILE_SIZE + 1),
    parameter int TCW = $clog2((65536 + TILE_SIZE - 1) / TILE_SIZE + 1),
    parameter int AW  = (MAX_SCALE_ENTRIES > 1) ? $clog2(MAX_SCALE_ENTRIES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  fp8dq_pkg::stage_t           s_in,
    input  logic [RTW-1:0]              row_tile,
    input  logic [RTW-1:0]              col_tile,
    input  logic [fp8dq_pkg::SLOT_W-1:0] slot,
    input  logic [fp8dq_pkg::CFG_W-1:0] cols_eff,
    output fp8dq_pkg::stage_t           s_out,
    output logic [AW-1:0]               addr
);
    import fp8dq_pkg::*;

    localparam int NW  = RTW + TCW + 1;
    localparam int TK  = 28;
    localparam longint unsigned RT = ((64'd1 << TK) + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TPW = CFG_W + 1 + 26;
    localparam int MK  = NW + ((MAX_SCALE_ENTRIES > 1) ? $clog2(MAX_SCALE_ENTRIES) : 0);
    localparam longint unsigned RM =
        ((64'd1 << MK) + MAX_SCALE_ENTRIES - 1) / MAX_SCALE_ENTRIES;
    localparam int PW  = NW + NW + 2;

    logic [TCW-1:0]   tile_cols_reg;
    logic [CFG_W:0]   ncols;
    logic [TPW-1:0]   tprod;
    stage_t           s2_reg;
    stage_t           s3_reg;
    logic [NW-1:0]    n2_reg;
    logic [NW-1:0]    n3_reg;
    logic [NW-1:0]    q3_reg;
    logic [NW-1:0]    n2_next;
    logic [PW-1:0]    qprod;
    logic [NW-1:0]    rem;

    // Tiles per row, ceil(cols / TILE_SIZE), by reciprocal multiplication.
    assign ncols = (CFG_W+1)'(cols_eff) + (CFG_W+1)'(TILE_SIZE - 1);
    assign tprod = TPW'(ncols) * TPW'(RT);

    always_ff @(posedge clk)
    begin
        tile_cols_reg <= TCW'(tprod >> TK);
    end

    assign n2_next = (s_in.action == ACT_WEIGHT)
                   ? NW'(NW'(row_tile) * NW'(tile_cols_reg) + NW'(col_tile))
                   : NW'(slot);
    assign qprod = PW'(n2_reg) * PW'(RM);
    assign rem   = n3_reg - NW'(q3_reg * NW'(MAX_SCALE_ENTRIES));
    assign addr  = AW'(rem);
    assign s_out = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (en)
        begin
            s2_reg <= s_in;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg <= n2_next;
            n3_reg <= n2_reg;
            q3_reg <= NW'(qprod >> MK);
        end
    end

endmodule

// ===== hw/rtl/fp8dq_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP8 dequantiser number conversion
// E4M3 weight times E8M0 scale, rounded to binary32 and then to BF16.
// ----------------------------------------------------------------------------
module fp8dq_convert (
    input  logic [7:0]  weight,
    input  logic [7:0]  scale,
    output logic [15:0] bf16
);

    logic               sign;
    logic [3:0]         ex;
    logic [2:0]         man;
    logic               nan;
    logic [3:0]         m4;
    logic [2:0]         nb;
    logic [2:0]         frac3;
    logic signed [10:0] biased;
    logic [9:0]         sh_full;
    logic [31:0]        sub;
    logic [31:0]        rnd;

    assign sign = weight[7];
    assign ex   = weight[6:3];
    assign man  = weight[2:0];
    assign nan  = (scale == 8'hFF) || ((ex == 4'hF) && (man == 3'h7));
    assign m4   = (ex == 4'h0) ? {1'b0, man} : {1'b1, man};

    always_comb
    begin
        priority if (m4[3])
        begin
            nb    = 3'd4;
            frac3 = m4[2:0];
        end
        else if (m4[2])
        begin
            nb    = 3'd3;
            frac3 = {m4[1:0], 1'b0};
        end
        else if (m4[1])
        begin
            nb    = 3'd2;
            frac3 = {m4[0], 2'b00};
        end
        else
        begin
            nb    = 3'd1;
            frac3 = 3'b000;
        end
    end

    assign biased = (ex == 4'h0)
                  ? $signed({3'b000, scale}) + $signed({8'h00, nb}) - 11'sd10
                  : $signed({3'b000, scale}) + $signed({7'h00, ex}) - 11'sd7;

    // Tiny results land in the binary32 subnormal range with a shift of 13 to 22.
    assign sh_full = (ex == 4'h0) ? ({2'b00, scale} + 10'd13)
                                  : ({2'b00, scale} + {6'h00, ex} + 10'd12);
    assign sub = 32'(m4) << sh_full[4:0];
    assign rnd = sub + 32'h0000_7FFF + 32'(sub[16]);

    always_comb
    begin
        priority if (nan)
        begin
            bf16 = 16'h7FC0;
        end
        else if (m4 == 4'h0)
        begin
            bf16 = {sign, 15'h0000};
        end
        else if (biased >= 11'sd255)
        begin
            bf16 = {sign, 8'hFF, 7'h00};
        end
        else if (biased >= 11'sd1)
        begin
            bf16 = {sign, biased[7:0], frac3, 4'h0};
        end
        else
        begin
            bf16 = {sign, rnd[30:16]};
        end
    end

endmodule

// ===== sim/fp8_block_scaled_dequant_bf16_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP8 block-scaled dequantiser testbench
// Streams scale writes and E4M3 weight bytes through the block across several
// matrix shapes, predicts each BF16 word and end-of-matrix flag, and checks
// every result transfer in order while both sides stall at random.
// ----------------------------------------------------------------------------
module fp8_block_scaled_dequant_bf16_test;

    import fp8dq_pkg::*;

    localparam int SLOTS      = 4096;
    localparam int TILE       = 128;
    localparam int DRAIN      = 10;
    localparam int LIMIT      = 400000;
    localparam int HOLD_LEN   = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = REG_ROW_COUNT;
    logic [CFG_W-1:0]   cfg_data = '0;

    fp8_block_scaled_dequant_bf16 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Items waiting to be offered, and the results they are expected to give.
    item_t   feed_queue[$];
    result_t expected_words[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    logic    calm = 1'b0;
    logic    squeeze = 1'b0;
    int      hold_left = 0;

    // Predictor state, advanced as transfers are accepted.
    logic [7:0]       tile_scales[SLOTS];
    int               row_pos = 0;
    int               col_pos = 0;
    logic [CFG_W-1:0] rows_reg = COUNT_RESET;
    logic [CFG_W-1:0] cols_reg = COUNT_RESET;

    // Stimulus-side copy of the positions, used to make sure every tile has
    // had its scale written before any weight of that tile is sent.
    bit               scale_known[SLOTS];
    int               gen_row = 0;
    int               gen_col = 0;
    logic [CFG_W-1:0] gen_rows = COUNT_RESET;
    logic [CFG_W-1:0] gen_cols = COUNT_RESET;

    // A count of zero in its low 16 bits stands for 65536.
    function automatic int span(input logic [CFG_W-1:0] reg_value);
        return (reg_value[15:0] == 16'd0) ? 65536 : int'(reg_value[15:0]);
    endfunction

    function automatic int tile_slot(input int r, input int c, input logic [CFG_W-1:0] creg);
        int tiles_across;
        tiles_across = (span(creg) + TILE - 1) / TILE;
        return ((r / TILE) * tiles_across + c / TILE) % SLOTS;
    endfunction

    // Moves a position pair on by one element; a position at or beyond its
    // count is treated as the end of the row or of the matrix.
    function automatic bit advance(inout int r, inout int c,
                                   input logic [CFG_W-1:0] rreg,
                                   input logic [CFG_W-1:0] creg);
        bit row_done;
        bit matrix_done;
        row_done    = (c + 1 >= span(creg));
        matrix_done = row_done && (r + 1 >= span(rreg));
        if (matrix_done)
        begin
            r = 0;
            c = 0;
        end
        else if (row_done)
        begin
            c = 0;
            r = (r + 1) & 16'hFFFF;
        end
        else
            c = (c + 1) & 16'hFFFF;
        return matrix_done;
    endfunction

    // E4M3 weight times 2^(scale-127), rounded to binary32 and then to BF16.
    function automatic logic [15:0] dequant_word(input logic [7:0] w, input logic [7:0] sc);
        logic [31:0] sign;
        logic [31:0] bits;
        logic [3:0]  ex;
        logic [2:0]  man;
        int          m;
        int          e;
        int          nb;
        int          biased;
        sign = w[7] ? 32'h8000_0000 : 32'h0;
        ex   = w[6:3];
        man  = w[2:0];
        if (sc == 8'hFF || (ex == 4'hF && man == 3'h7))
            return 16'h7FC0;
        if (ex == 4'h0)
        begin
            m = man;
            e = -9;
        end
        else
        begin
            m = 8 + man;
            e = int'(ex) - 10;
        end
        if (m == 0)
            return sign[31:16];
        e = e + int'(sc) - 127;
        nb = (m >= 8) ? 4 : (m >= 4) ? 3 : (m >= 2) ? 2 : 1;
        biased = e + nb - 1 + 127;
        if (biased >= 255)
            bits = sign | 32'h7F80_0000;
        else if (biased >= 1)
            bits = sign | (32'(biased) << 23) | ((32'(m) << (24 - nb)) & 32'h007F_FFFF);
        else
            bits = sign | (32'(m) << (e + 149));
        if (bits[30:23] != 8'hFF)
            bits = bits + 32'h7FFF + {31'b0, bits[16]};
        return bits[31:16];
    endfunction

    // Applies one accepted item to the predictor state.
    task automatic predict(input item_t it);
        result_t r;
        int      slot;
        if (it.action == ACT_SCALE)
            tile_scales[it.scale_slot] = it.data_byte;
        else
        begin
            slot           = tile_slot(row_pos, col_pos, cols_reg);
            r.bf16_word    = dequant_word(it.data_byte, tile_scales[slot]);
            r.last_element = advance(row_pos, col_pos, rows_reg, cols_reg);
            expected_words = {expected_words, r};
        end
    endtask

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic queue_scale(input int slot, input logic [7:0] value);
        item_t it;
        it.action     = ACT_SCALE;
        it.scale_slot = SLOT_W'(slot);
        it.data_byte  = value;
        scale_known[slot % SLOTS] = 1'b1;
        feed_queue = {feed_queue, it};
    endtask

    // Scales lean towards the region where results stay normal, with the
    // extremes mixed in so that overflow, subnormals and NaN all appear.
    function automatic logic [7:0] pick_scale();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'hFE;
            3: return 8'($urandom_range(255));
            default: return 8'($urandom_range(145, 110));
        endcase
    endfunction

    // Queues one weight, writing its tile scale first if none has been written.
    task automatic queue_weight(input logic [7:0] w);
        item_t it;
        int    slot;
        slot = tile_slot(gen_row, gen_col, gen_cols);
        if (!scale_known[slot])
            queue_scale(slot, pick_scale());
        it.action     = ACT_WEIGHT;
        it.scale_slot = SLOT_W'($urandom_range(4095));
        it.data_byte  = w;
        feed_queue = {feed_queue, it};
        void'(advance(gen_row, gen_col, gen_rows, gen_cols));
    endtask

    task automatic write_count(input logic [0:0] index, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index == REG_ROW_COUNT)
        begin
            rows_reg = value;
            gen_rows = value;
        end
        else
        begin
            cols_reg = value;
            gen_cols = value;
        end
    endtask

    // Waits for every queued transfer and result, then lets the pipeline empty.
    task automatic settle();
        while (feed_queue.size() != 0 || item_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_run(input int weights);
        int i;
        int slot;
        for (i = 0; i < weights; i++)
        begin
            // Occasional scale writes, both to the tile in use and anywhere.
            if ($urandom_range(99) < 10)
            begin
                slot = ($urandom_range(1) == 0) ? tile_slot(gen_row, gen_col, gen_cols)
                                                : $urandom_range(4095);
                queue_scale(slot, pick_scale());
            end
            queue_weight(8'($urandom_range(255)));
        end
    endtask

    // Sender: offers the head of the queue and holds it until it is taken.
    logic took;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            took = item_valid && item_ready;
            if (took)
            begin
                predict(item);
                void'(feed_queue.pop_front());
            end
            if (item_valid && !took)
                ;
            else if (feed_queue.size() != 0 && (calm || $urandom_range(99) >= 12))
            begin
                item_valid <= 1'b1;
                item       <= feed_queue[0];
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted on its own so the block fills and stalls.
    always @(posedge clk)
    begin
        if (squeeze)
            hold_left <= HOLD_LEN;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each result transfer against the oldest expectation.
    result_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                    report($sformatf("unexpected result %h", result));
                else
                begin
                    want = expected_words.pop_front();
                    if (result.bf16_word !== want.bf16_word)
                        report($sformatf("bf16_word %h, wanted %h",
                                         result.bf16_word, want.bf16_word));
                    if (result.last_element !== want.last_element)
                        report($sformatf("last_element %b, wanted %b",
                                         result.last_element, want.last_element));
                end
            end
            result_ready <= (hold_left == 0) && !squeeze && (calm || $urandom_range(99) >= 12);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int w;
        int p;
        logic [7:0] edge_weights[16];
        edge_weights = '{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h81, 8'h07, 8'h08,
                         8'h7E, 8'hFE, 8'h38, 8'hB8, 8'h0F, 8'h77, 8'h55, 8'hAA};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset counts: unit scale over the edge weights,
        // then a NaN scale, the smallest scale and one large enough to overflow.
        queue_scale(0, 8'd127);
        for (w = 0; w < 12; w++)
            queue_weight(edge_weights[w]);
        queue_scale(0, 8'hFF);
        queue_weight(8'h38);
        queue_scale(0, 8'h00);
        queue_weight(8'h01);
        queue_weight(8'h7E);
        queue_scale(0, 8'hFE);
        queue_weight(8'h7E);
        queue_weight(8'hF0);
        settle();

        // A one-by-one matrix marks every element as the last.
        write_count(REG_ROW_COUNT, 17'd1);
        write_count(REG_COLUMN_COUNT, 17'd1);
        for (w = 12; w < 16; w++)
            queue_weight(edge_weights[w]);
        settle();

        // Shapes, including the largest counts and values that wrap.
        for (p = 0; p < 11; p++)
        begin
            case (p)
                0: begin write_count(REG_ROW_COUNT, 17'h10000);
                         write_count(REG_COLUMN_COUNT, 17'h10000); end
                1: begin write_count(REG_ROW_COUNT, 17'h1FFFF);
                         write_count(REG_COLUMN_COUNT, 17'd0); end
                2: begin write_count(REG_ROW_COUNT, 17'd3);
                         write_count(REG_COLUMN_COUNT, 17'd300); end
                3: begin write_count(REG_ROW_COUNT, 17'd300);
                         write_count(REG_COLUMN_COUNT, 17'd2); end
                4: begin write_count(REG_ROW_COUNT, 17'd1);
                         write_count(REG_COLUMN_COUNT, 17'd1); end
                default: begin
                    write_count(REG_ROW_COUNT, 17'($urandom_range(20, 1)));
                    write_count(REG_COLUMN_COUNT, 17'($urandom_range(260, 1)));
                end
            endcase
            calm = (p == 6);
            random_run(p < 2 ? 150 : 110);
            if (p == 3)
            begin
                @(posedge clk);
                squeeze <= 1'b1;
                @(posedge clk);
                squeeze <= 1'b0;
            end
            settle();
        end
        calm = 1'b0;

        if (expected_words.size() != 0)
            report("results still outstanding at the end");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fp8dq_pkg.sv
hw/rtl/fp8dq_ram.sv
hw/rtl/fp8dq_index.sv
hw/rtl/fp8dq_convert.sv
hw/rtl/fp8_block_scaled_dequant_bf16.sv
sim/fp8_block_scaled_dequant_bf16_test.sv
